/* sv/p8addsub_pkg.sv */
// Shared types, constants and the operand decoder for the posit<8,2> adder.
// No dependencies.

package p8addsub_pkg;

    localparam int POSIT_W = 8;
    localparam int SIG_W   = 11;   // hidden one at bit SIG_W-1, ten fraction bits
    localparam int SCL_W   = 6;    // decoded scale, -24 .. 24
    localparam int NSCL_W  = 7;    // scale after normalising, -35 .. 25

    localparam logic [POSIT_W-1:0] NAR_PAT = 8'h80;
    localparam logic [POSIT_W-1:0] ZERO_PAT = 8'h00;
    localparam logic [POSIT_W-2:0] MAXPOS_BODY = 7'h7f;
    localparam logic [POSIT_W-2:0] MINPOS_BODY = 7'h01;

    typedef struct packed {
        logic                    neg;
        logic signed [SCL_W-1:0] scale;
        logic [3:0]              sig;     // hidden one and three fraction bits
    } unpk_t;

    // Sign, scale and significand of a posit that is neither zero nor NaR
    function automatic unpk_t decode(input logic [POSIT_W-1:0] p);
        unpk_t      u;
        logic [7:0] mag;
        logic       rc;
        logic       run;
        logic [2:0] m;
        logic [3:0] mw;
        logic [3:0] k;
        logic [6:0] rest;
        mag = p[7] ? (8'd0 - p) : p;
        rc  = mag[6];
        run = 1'b1;
        m   = 3'd0;
        for (int i = 6; i >= 0; i--) begin
            if (run && (mag[i] == rc)) begin
                m = m + 3'd1;
            end else begin
                run = 1'b0;
            end
        end
        mw   = {1'b0, m};
        rest = mag[6:0] << (mw + 4'd1);
        k    = rc ? (mw - 4'd1) : (4'd0 - mw);
        // 4k + e is just the two fields side by side
        u.neg   = p[7];
        u.scale = {k, rest[6:5]};
        u.sig   = {1'b1, rest[4:2]};
        return u;
    endfunction

endpackage

/* sv/posit8_es2_add_sub.sv */
// Posit<8,2> adder/subtractor, four-stage pipeline with per-stage valid bits.
// Depends on p8addsub_pkg (types, decoder, special patterns).
//
//  channel | ports                       | contents
//  --------+-----------------------------+-------------------------------------
//  input   | s_tvalid s_tready s_tdata   | tdata[7:0] operand_a, [15:8] operand_b
//          | s_tuser                     | tuser[0] op (1 = subtract)
//  result  | m_tvalid m_tready m_tdata   | tdata[7:0] sum_bits
//          | m_tuser                     | tuser[0] is_nar
//
// One transfer per cycle sustained while m_tready is held high; the stages in order
// from input transfer to result valid: decode, align/add, normalise, round/encode.
// Each stage has its own valid bit and holds while the stage after it is
// full and stalled, so bubbles close up and nothing is dropped or repeated.
// aresetn clears the valid bits only.

module posit8_es2_add_sub
    import p8addsub_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] operand_a, [15:8] operand_b
    input  logic [0:0]  s_tuser,    // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] sum_bits
    output logic [0:0]  m_tuser     // [0] is_nar
);

    // ---------------- valid chain ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = ~v4_reg | m_tready;
    assign rdy3     = ~v3_reg | rdy4;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: decode ----------------
    logic [7:0] opa, opb;
    logic       spec1_next;
    logic [7:0] sval1_next;
    unpk_t      ua1_next, ub1_next;

    logic       spec1_reg;
    logic [7:0] sval1_reg;
    unpk_t      ua1_reg, ub1_reg;

    always_comb begin
        opa = s_tdata[7:0];
        opb = s_tuser[0] ? (8'd0 - s_tdata[15:8]) : s_tdata[15:8];
        spec1_next = 1'b1;
        if ((opa == NAR_PAT) || (opb == NAR_PAT)) begin
            sval1_next = NAR_PAT;
        end else if (opa == ZERO_PAT) begin
            sval1_next = opb;
        end else if (opb == ZERO_PAT) begin
            sval1_next = opa;
        end else begin
            sval1_next = ZERO_PAT;
            spec1_next = 1'b0;
        end
        ua1_next = decode(opa);
        ub1_next = decode(opb);
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            spec1_reg <= spec1_next;
            sval1_reg <= sval1_next;
            ua1_reg   <= ua1_next;
            ub1_reg   <= ub1_next;
        end
    end

    // ---------------- stage 2: order, align, add ----------------
    unpk_t                   big, sml;
    logic [NSCL_W-1:0]       diff;
    logic [SIG_W-1:0]        big_sig, sml_sig, aln;
    logic                    eff_sub;
    logic [SIG_W:0]          sum2_next;
    logic                    spec2_next;
    logic [7:0]              sval2_next;

    logic                    spec2_reg;
    logic [7:0]              sval2_reg;
    logic                    neg2_reg;
    logic signed [SCL_W-1:0] scale2_reg;
    logic [SIG_W:0]          sum2_reg;

    always_comb begin
        // scale above significand, so one signed compare orders the magnitudes
        if ($signed({ua1_reg.scale, ua1_reg.sig}) >= $signed({ub1_reg.scale, ub1_reg.sig}))
        begin
            big = ua1_reg;
            sml = ub1_reg;
        end else begin
            big = ub1_reg;
            sml = ua1_reg;
        end
        diff    = {big.scale[SCL_W-1], big.scale} - {sml.scale[SCL_W-1], sml.scale};
        big_sig = {big.sig, 7'd0};
        sml_sig = {sml.sig, 7'd0};
        if (diff >= NSCL_W'(SIG_W)) begin
            aln = {{(SIG_W-1){1'b0}}, 1'b1};
        end else begin
            aln = (sml_sig >> diff[3:0])
                | {{(SIG_W-1){1'b0}}, |(sml_sig & ~({SIG_W{1'b1}} << diff[3:0]))};
        end
        eff_sub   = big.neg ^ sml.neg;
        sum2_next = eff_sub ? ({1'b0, big_sig} - {1'b0, aln})
                            : ({1'b0, big_sig} + {1'b0, aln});
        // exact cancellation gives zero
        spec2_next = spec1_reg | (eff_sub && (sum2_next == '0));
        sval2_next = spec1_reg ? sval1_reg : ZERO_PAT;
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            spec2_reg  <= spec2_next;
            sval2_reg  <= sval2_next;
            neg2_reg   <= big.neg;
            scale2_reg <= big.scale;
            sum2_reg   <= sum2_next;
        end
    end

    // ---------------- stage 3: normalise ----------------
    logic [3:0]               lz;
    logic                     found;
    logic [SIG_W-1:0]         sig3_next;
    logic signed [NSCL_W-1:0] scale3_next;
    logic signed [NSCL_W-1:0] scale2_ext;

    logic                     spec3_reg;
    logic [7:0]               sval3_reg;
    logic                     neg3_reg;
    logic signed [NSCL_W-1:0] scale3_reg;
    logic [SIG_W-1:0]         sig3_reg;

    always_comb begin
        lz    = 4'd0;
        found = 1'b0;
        for (int i = SIG_W - 1; i >= 0; i--) begin
            if (!found) begin
                if (sum2_reg[i]) found = 1'b1;
                else             lz    = lz + 4'd1;
            end
        end
        scale2_ext = {scale2_reg[SCL_W-1], scale2_reg};
        if (sum2_reg[SIG_W]) begin
            // carry out: shift right, keep the dropped bit as sticky
            sig3_next   = sum2_reg[SIG_W:1] | {{(SIG_W-1){1'b0}}, sum2_reg[0]};
            scale3_next = scale2_ext + NSCL_W'(1);
        end else begin
            sig3_next   = sum2_reg[SIG_W-1:0] << lz;
            scale3_next = scale2_ext - $signed({3'd0, lz});
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            spec3_reg  <= spec2_reg;
            sval3_reg  <= sval2_reg;
            neg3_reg   <= neg2_reg;
            scale3_reg <= scale3_next;
            sig3_reg   <= sig3_next;
        end
    end

    // ---------------- stage 4: round and encode ----------------
    logic signed [4:0] k;
    logic [6:0]        ones;
    logic [6:0]        regime;
    logic [4:0]        r_wide;
    logic [2:0]        r;
    logic [11:0]       tail;
    logic [18:0]       y;
    logic [6:0]        body;
    logic              rnd, stk;
    logic [7:0]        enc;
    logic [7:0]        res4_next;

    logic [7:0]        sum4_reg;
    logic              nar4_reg;

    always_comb begin
        k      = scale3_reg[NSCL_W-1:2];
        ones   = 7'h7f >> (3'd6 - k[2:0]);
        tail   = {scale3_reg[1:0], sig3_reg[SIG_W-2:0]};
        if (k[4]) begin
            regime = 7'd1;
            r_wide = 5'd1 - k;
        end else begin
            regime = {ones[5:0], 1'b0};
            r_wide = k + 5'd2;
        end
        r    = r_wide[2:0];
        // regime, exponent and fraction in one word, body in the top seven bits
        y    = {regime, tail} << (3'd7 - r);
        rnd  = y[11];
        stk  = |y[10:0];
        if (k > 5'sd5) begin
            body = MAXPOS_BODY;
        end else if (k < -5'sd6) begin
            body = MINPOS_BODY;
        end else begin
            body = y[18:12] + {6'd0, rnd & (stk | y[12])};
        end
        enc       = neg3_reg ? (8'd0 - {1'b0, body}) : {1'b0, body};
        res4_next = spec3_reg ? sval3_reg : enc;
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            sum4_reg <= res4_next;
            nar4_reg <= (res4_next == NAR_PAT);
        end
    end

    assign m_tdata    = sum4_reg;
    assign m_tuser[0] = nar4_reg;

endmodule

/* verif/posit_sum_checker.sv */
`timescale 1ns / 100ps
// Watches both channels of posit8_es2_add_sub and predicts each posit<8,2> sum or difference.
// Compares every result transfer against the oldest prediction. Needs p8addsub_pkg.

module posit_sum_checker
    import p8addsub_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] operand_a, [15:8] operand_b
    input  logic [0:0]  s_tuser,    // [0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [7:0] sum_bits
    input  logic [0:0]  m_tuser,    // [0] is_nar
    output int          mismatches,
    output int          awaiting
);

    localparam int ES  = 2;
    localparam int HID = 40;        // hidden one of the wide significand

    typedef struct packed {
        logic               zero;
        logic               nar;
        logic               neg;
        logic signed [31:0] scale;
        logic [63:0]        sig;
    } posit_parts_t;

    typedef struct packed {
        logic [7:0] sum_bits;
        logic       is_nar;
    } posit_result_t;

    posit_result_t pending_sums[$];
    posit_result_t want;
    posit_result_t seen;
    int            errs;

    function automatic posit_parts_t split_posit(input logic [7:0] p);
        posit_parts_t u;
        logic [7:0]   mag;
        logic         rc;
        logic         counting;
        int           run;
        int           k;
        int           rb;
        int           nf;
        logic [63:0]  rest;
        logic [63:0]  ex;
        logic [63:0]  frac;
        u       = '0;
        u.zero  = (p == ZERO_PAT);
        u.nar   = (p == NAR_PAT);
        u.neg   = p[7];
        if (u.zero || u.nar) return u;
        mag      = p[7] ? (8'd0 - p) : p;
        rc       = mag[6];
        run      = 0;
        counting = 1'b1;
        for (int i = 6; i >= 0; i--) begin
            if (counting && mag[i] == rc) run++;
            else counting = 1'b0;
        end
        k  = rc ? run - 1 : -run;
        rb = 6 - run;
        if (rb < 0) rb = 0;
        rest = {56'd0, mag} & ((64'd1 << rb) - 64'd1);
        if (rb >= ES) begin
            ex = rest >> (rb - ES);
            nf = rb - ES;
        end else begin
            ex = rest << (ES - rb);   // exponent bits cut off by the regime read as zero
            nf = 0;
        end
        frac    = rest & ((64'd1 << nf) - 64'd1);
        u.scale = k * (1 << ES) + int'(ex);
        u.sig   = (64'd1 << HID) | (frac << (HID - nf));
        return u;
    endfunction

    function automatic logic [7:0] pack_posit(input logic neg, input int scale,
                                              input logic [63:0] sig);
        int          k;
        int          r;
        int          rem;
        int          cut;
        logic [63:0] ex;
        logic [63:0] tail;
        logic [63:0] regime;
        logic [63:0] keep;
        logic [63:0] body;
        logic [63:0] rnd;
        logic [63:0] stk;
        k  = scale >>> ES;
        ex = 64'(scale - k * (1 << ES));
        if (k > 5) begin
            body = {57'd0, MAXPOS_BODY};
        end else if (k < -6) begin
            body = {57'd0, MINPOS_BODY};
        end else begin
            if (k >= 0) begin
                r      = k + 2;
                regime = ((64'd1 << (k + 1)) - 64'd1) << 1;
            end else begin
                r      = 1 - k;
                regime = 64'd1;
            end
            rem  = 7 - r;
            tail = (ex << HID) | (sig & ((64'd1 << HID) - 64'd1));
            cut  = HID + ES - rem;
            keep = tail >> cut;
            rnd  = (tail >> (cut - 1)) & 64'd1;
            stk  = tail & ((64'd1 << (cut - 1)) - 64'd1);
            body = (regime << rem) | keep;
            // nearest, ties to even; carry into the regime saturates at maxpos on its own
            if (rnd[0] && (stk != 0 || body[0])) body = body + 64'd1;
        end
        if (neg) body = 64'd0 - body;
        return body[7:0];
    endfunction

    function automatic logic [7:0] posit_sum(input logic subtract, input logic [7:0] a,
                                             input logic [7:0] b_in);
        logic [7:0]   b;
        posit_parts_t x;
        posit_parts_t y;
        posit_parts_t big;
        posit_parts_t lit;
        logic [63:0]  s;
        logic [63:0]  ls;
        int           diff;
        int           scale;
        b = subtract ? (8'd0 - b_in) : b_in;
        x = split_posit(a);
        y = split_posit(b);
        if (x.nar || y.nar) return NAR_PAT;
        if (x.zero) return b;
        if (y.zero) return a;
        if (x.scale > y.scale || (x.scale == y.scale && x.sig >= y.sig)) begin
            big = x;
            lit = y;
        end else begin
            big = y;
            lit = x;
        end
        diff = big.scale - lit.scale;
        if (diff > HID + 2) begin
            s = 64'd1;
        end else begin
            s = lit.sig >> diff;
            if ((lit.sig & ((64'd1 << diff) - 64'd1)) != 0) s = s | 64'd1;
        end
        scale = big.scale;
        if (big.neg == lit.neg) begin
            ls = big.sig + s;
            if (ls[HID+1]) begin
                ls = (ls >> 1) | (ls & 64'd1);
                scale++;
            end
        end else begin
            ls = big.sig - s;
            if (ls == 0) return ZERO_PAT;
            while (!ls[HID]) begin
                ls = ls << 1;
                scale--;
            end
        end
        return pack_posit(big.neg, scale, ls);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_sums.delete();
            mismatches <= 0;
            awaiting   <= 0;
        end else begin
            errs = 0;
            // retire first so a same-edge input transfer never meets its own result
            if (m_tvalid && m_tready) begin
                seen = '{sum_bits: m_tdata, is_nar: m_tuser[0]};
                if (pending_sums.size() == 0) begin
                    $display("%0t: result %02h/%0b with nothing outstanding",
                             $time, seen.sum_bits, seen.is_nar);
                    errs = errs + 1;
                end else begin
                    want = pending_sums.pop_front();
                    if (seen.sum_bits !== want.sum_bits) begin
                        $display("%0t: sum_bits expected %02h, got %02h",
                                 $time, want.sum_bits, seen.sum_bits);
                        errs = errs + 1;
                    end
                    if (seen.is_nar !== want.is_nar) begin
                        $display("%0t: is_nar expected %0b, got %0b",
                                 $time, want.is_nar, seen.is_nar);
                        errs = errs + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want.sum_bits = posit_sum(s_tuser[0], s_tdata[7:0], s_tdata[15:8]);
                want.is_nar   = (want.sum_bits == NAR_PAT);
                pending_sums.push_back(want);
            end
            mismatches <= mismatches + errs;
            awaiting   <= pending_sums.size();
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Top of the posit8_es2_add_sub bench: clock, reset, operand stimulus and result back-pressure.
// Depends on p8addsub_pkg, posit8_es2_add_sub and posit_sum_checker.

module tb_top
    import p8addsub_pkg::*;
();

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   LONG_HOLD   = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    int mismatches;
    int awaiting;
    int cycles = 0;
    int sender_quiet;
    int receiver_quiet;
    int hold_req = 0;

    posit8_es2_add_sub dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    posit_sum_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one operand pair; the valid stays high straight into the next transfer when there is no gap
    task automatic send_pair(input logic op, input logic [7:0] a, input logic [7:0] b);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_operand();
        if ($urandom_range(0, 4) != 0) return 8'($urandom);
        case ($urandom_range(0, 7))
            0:       return ZERO_PAT;
            1:       return NAR_PAT;
            2:       return 8'h7f;
            3:       return 8'h01;
            4:       return 8'h81;
            5:       return 8'hff;
            6:       return 8'h40;
            default: return 8'hc0;
        endcase
    endfunction

    task automatic send_random(input int count);
        logic       op;
        logic [7:0] a;
        logic [7:0] b;
        repeat (count) begin
            op = 1'($urandom);
            a  = pick_operand();
            b  = pick_operand();
            // near cancellation exercises the normalising shifts
            if ($urandom_range(0, 3) == 0)
                b = (op == OP_SUB ? a : 8'd0 - a) + 8'($urandom_range(0, 4)) - 8'd2;
            send_pair(op, a, b);
        end
    endtask

    // result side: random stalls, an optional long hold-off, and quiet stretches
    initial begin
        int stall;
        int holds_done;
        m_tready   = 1'b0;
        holds_done = 0;
        @(posedge aresetn);
        forever begin
            stall = receiver_quiet ? 0 : $urandom_range(0, 9);
            if (hold_req != holds_done) begin
                stall      = LONG_HOLD;
                holds_done = hold_req;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        sender_quiet   = 0;
        receiver_quiet = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_ADD;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: NaR, zero operands, cancellation, saturation, signs and rounding
        send_pair(OP_ADD, NAR_PAT, 8'h40);
        send_pair(OP_ADD, 8'h40, NAR_PAT);
        send_pair(OP_SUB, NAR_PAT, NAR_PAT);
        send_pair(OP_SUB, 8'h12, NAR_PAT);
        send_pair(OP_ADD, ZERO_PAT, 8'h5a);
        send_pair(OP_SUB, ZERO_PAT, 8'h5a);
        send_pair(OP_ADD, 8'ha5, ZERO_PAT);
        send_pair(OP_SUB, 8'ha5, ZERO_PAT);
        send_pair(OP_ADD, ZERO_PAT, ZERO_PAT);
        send_pair(OP_SUB, 8'h40, 8'h40);
        send_pair(OP_ADD, 8'h40, 8'hc0);
        send_pair(OP_ADD, 8'h7f, 8'h7f);
        send_pair(OP_SUB, 8'h7f, 8'h81);
        send_pair(OP_ADD, 8'h81, 8'h81);
        send_pair(OP_ADD, 8'h01, 8'h01);
        send_pair(OP_SUB, 8'h02, 8'h01);
        send_pair(OP_ADD, 8'hff, 8'h01);
        send_pair(OP_SUB, 8'h01, 8'h7f);
        send_pair(OP_ADD, 8'h40, 8'h40);
        send_pair(OP_ADD, 8'h40, 8'h01);
        send_pair(OP_ADD, 8'h4f, 8'h31);
        send_pair(OP_SUB, 8'h7e, 8'h3f);
        send_pair(OP_ADD, 8'hbf, 8'hc1);
        s_tvalid <= 1'b0;
        wait (awaiting == 0);
        @(negedge aclk);

        send_random(280);

        // hold the result side off while the input keeps pushing, so the pipe backs up
        hold_req     = hold_req + 1;
        sender_quiet = 1;
        send_random(40);
        sender_quiet = 0;
        s_tvalid <= 1'b0;
        wait (awaiting == 0);
        @(negedge aclk);

        sender_quiet   = 1;
        receiver_quiet = 1;
        send_random(150);
        sender_quiet   = 0;
        receiver_quiet = 0;

        send_random(180);
        s_tvalid <= 1'b0;

        wait (awaiting == 0);
        repeat (12) @(posedge aclk);
        if (mismatches == 0 && awaiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
sv/p8addsub_pkg.sv
sv/posit8_es2_add_sub.sv
verif/posit_sum_checker.sv
verif/tb_top.sv
